// ===== sv/pmfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the paged monochrome frame store pixel engine.
package pmfb_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;

    localparam int PAGE_ROWS = 8;
    localparam int ROW_BITS  = 3;
    localparam int BYTE_W    = 8;
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 9;
    localparam int CMD_W     = 2;
    localparam int COLOR_W   = 2;
    localparam int IDX_W     = 10;
    localparam int ROT_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_CLEAR  = 2'd0,
        COLOR_SET    = 2'd1,
        COLOR_TOGGLE = 2'd2,
        COLOR_KEEP   = 2'd3
    } t_color;

    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

endpackage

// ===== sv/pmfb_in_if.sv =====
`timescale 1ns / 1ps
// Command channel interface of the pixel engine.
interface pmfb_in_if;
    import pmfb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [COLOR_W-1:0]        color;
    logic [IDX_W-1:0]          byte_index;

    modport source (output valid, cmd, x_coord, y_coord, color, byte_index, input ready);
    modport sink   (input valid, cmd, x_coord, y_coord, color, byte_index, output ready);
endinterface

// ===== sv/pmfb_out_if.sv =====
`timescale 1ns / 1ps
// Result channel interface of the pixel engine.
interface pmfb_out_if;
    import pmfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic              pixel_written;

    modport source (output valid, read_byte, pixel_written, input ready);
    modport sink   (input valid, read_byte, pixel_written, output ready);
endinterface

// ===== sv/pmfb_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
module pmfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/paged_mono_framebuffer_pixel_engine.sv =====
`timescale 1ns / 1ps
// Top level of the paged monochrome frame store pixel engine.
//
// Channels: i_in carries commands (draw pixel, clear store, read byte) as
// valid/ready beats; o_out returns one result beat per command, holding
// read_byte and pixel_written. i_cfg_we/i_cfg_wdata write the rotation
// register; write it only while the block is idle.
// Commands: a draw, read or unused command goes through ST_RMW; the single
// store RAM port pair does one read, then one write back, so the engine takes
// no new command until it is back in ST_IDLE.
// A clear walks the store one byte per cycle and gives its result once the
// walk has written the last byte.
// Reset: a synchronous low i_rst_n starts a zeroing pass over all STORE_BYTES
// bytes of the store (1024 at 128 x 64); i_in.ready stays low meanwhile and
// rotation returns to 0.
// Stall: the result register holds while o_out.ready is low; one more
// command is still accepted and its result parks in a holding register
// until the output drains.
module paged_mono_framebuffer_pixel_engine #(
    parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pmfb_pkg::ROT_W-1:0]  i_cfg_wdata,
    pmfb_in_if.sink                     i_in,
    pmfb_out_if.source                  o_out
);
    import pmfb_pkg::*;

    localparam int STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = COORD_W + 1;

    localparam logic signed [CW-1:0] W_LIM = CW'(PANEL_WIDTH);
    localparam logic signed [CW-1:0] H_LIM = CW'(PANEL_HEIGHT);
    localparam logic signed [CW-1:0] W_MAX = CW'(PANEL_WIDTH - 1);
    localparam logic signed [CW-1:0] H_MAX = CW'(PANEL_HEIGHT - 1);
    localparam logic [AW-1:0]        LAST  = AW'(STORE_BYTES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_HOLD
    } t_state;

    t_state              r_state;
    logic [ROT_W-1:0]    r_rotation;
    logic [AW-1:0]       r_clr_ptr;
    logic                r_clr_item;
    logic [CMD_W-1:0]    r_cmd;
    logic                r_hit;
    logic [AW-1:0]       r_addr;
    logic [ROW_BITS-1:0] r_bit;
    logic [COLOR_W-1:0]  r_color;
    logic                r_rd_ok;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_wr;
    logic [BYTE_W-1:0]   r_pend_byte;
    logic                r_pend_wr;

    logic                 in_ready;
    logic                 accept;
    logic                 out_free;
    logic signed [CW-1:0] x_s;
    logic signed [CW-1:0] y_s;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic                 pre_hit;
    logic                 m_hit;
    logic [AW-1:0]        m_addr;
    logic                 rd_ok;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic [BYTE_W-1:0]    ram_rdata;
    logic [BYTE_W-1:0]    mask;
    logic [BYTE_W-1:0]    mod_byte;
    logic [BYTE_W-1:0]    res_byte;
    logic                 res_wr;

    assign in_ready = (r_state == ST_IDLE);
    assign accept   = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign x_s = {i_in.x_coord[COORD_W-1], i_in.x_coord};
    assign y_s = {i_in.y_coord[COORD_W-1], i_in.y_coord};

    assign pre_hit = !x_s[CW-1] && (x_s < W_LIM) && !y_s[CW-1] && (y_s < H_LIM);

    always_comb begin
        case (r_rotation)
            ROT_90: begin
                nx = W_MAX - y_s;
                ny = x_s;
            end
            ROT_180: begin
                nx = W_MAX - x_s;
                ny = H_MAX - y_s;
            end
            ROT_270: begin
                nx = y_s;
                ny = H_MAX - x_s;
            end
            default: begin
                nx = x_s;
                ny = y_s;
            end
        endcase
    end

    assign m_hit  = pre_hit && !nx[CW-1] && (nx < W_LIM) && !ny[CW-1] && (ny < H_LIM);
    assign m_addr = AW'(ny[PIX_W-1:ROW_BITS]) * AW'(PANEL_WIDTH) + AW'(nx[PIX_W-1:0]);
    assign rd_ok  = (32'(i_in.byte_index) < STORE_BYTES);

    assign ram_raddr = (i_in.cmd == CMD_READ) ? AW'(i_in.byte_index) : m_addr;

    assign mask = BYTE_W'(1) << r_bit;

    always_comb begin
        case (r_color)
            COLOR_CLEAR:  mod_byte = ram_rdata & ~mask;
            COLOR_SET:    mod_byte = ram_rdata | mask;
            COLOR_TOGGLE: mod_byte = ram_rdata ^ mask;
            default:      mod_byte = ram_rdata;
        endcase
    end

    always_comb begin
        res_byte = '0;
        res_wr   = 1'b0;
        if (r_state == ST_RMW) begin
            if (r_cmd == CMD_READ && r_rd_ok) begin
                res_byte = ram_rdata;
            end
            res_wr = (r_cmd == CMD_DRAW) && r_hit;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = mod_byte;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_ptr;
                ram_wdata = '0;
            end
            ST_RMW: begin
                ram_we = (r_cmd == CMD_DRAW) && r_hit && (r_color != COLOR_KEEP);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    pmfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rotation  <= '0;
            r_clr_ptr   <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rotation <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_in.cmd;
                        r_hit   <= m_hit;
                        r_addr  <= m_addr;
                        r_bit   <= ny[ROW_BITS-1:0];
                        r_color <= i_in.color;
                        r_rd_ok <= rd_ok;
                        if (i_in.cmd == CMD_CLEAR) begin
                            r_clr_ptr  <= '0;
                            r_clr_item <= 1'b1;
                            r_state    <= ST_CLEAR;
                        end else begin
                            r_state <= ST_RMW;
                        end
                    end
                end
                ST_RMW: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= res_byte;
                        r_out_wr    <= res_wr;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_pend_byte <= res_byte;
                        r_pend_wr   <= res_wr;
                        r_state     <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_pend_byte;
                        r_out_wr    <= r_pend_wr;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + AW'(1);
                    if (r_clr_ptr == LAST) begin
                        r_clr_ptr  <= '0;
                        r_clr_item <= 1'b0;
                        if (!r_clr_item) begin
                            r_state <= ST_IDLE;
                        end else if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_byte  <= '0;
                            r_out_wr    <= 1'b0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_pend_byte <= '0;
                            r_pend_wr   <= 1'b0;
                            r_state     <= ST_HOLD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.read_byte     = r_out_byte;
    assign o_out.pixel_written = r_out_wr;
endmodule

// ===== sv/pmfb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the pixel engine and its bind to the top level.
module pmfb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pmfb_pkg::BYTE_W-1:0] i_read_byte,
    input logic                        i_pixel_written
);
    import pmfb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_read_byte) && $stable(i_pixel_written))
        else $error("stalled result beat changed");

    a_read_vs_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_byte != '0) |-> !i_pixel_written)
        else $error("result carries both read data and a draw flag");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("command accepted during reset zeroing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while previous one in flight");
endmodule

bind paged_mono_framebuffer_pixel_engine pmfb_checker u_pmfb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_read_byte     (o_out.read_byte),
    .i_pixel_written (o_out.pixel_written)
);

// ===== tb/tb_paged_mono_framebuffer_pixel_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the paged monochrome frame store pixel engine.
module tb_paged_mono_framebuffer_pixel_engine;
    import pmfb_pkg::*;

    localparam int W = PANEL_WIDTH_DEF;
    localparam int H = PANEL_HEIGHT_DEF;
    localparam int STORE_BYTES = W * ((H + PAGE_ROWS - 1) / PAGE_ROWS);
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RESULT_LATENCY = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int PHASE_BEATS = 68;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              pixel_written;
    } t_pixel_result;

    class pixel_scoreboard;
        logic [BYTE_W-1:0] frame [STORE_BYTES];
        logic [ROT_W-1:0]  rotation;
        t_pixel_result     awaited[$];
        int                mismatches;

        function new();
            foreach (frame[i]) frame[i] = '0;
            rotation = ROT_0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] x,
                                   logic signed [COORD_W-1:0] y, logic [COLOR_W-1:0] color,
                                   logic [IDX_W-1:0] idx);
            int sx, sy, nx, ny, addr;
            logic [BYTE_W-1:0] mask;
            t_pixel_result res;
            sx = x;
            sy = y;
            res = '0;
            if (cmd == CMD_DRAW) begin
                if (sx >= 0 && sx < W && sy >= 0 && sy < H) begin
                    case (rotation)
                        ROT_90: begin
                            nx = W - 1 - sy;
                            ny = sx;
                        end
                        ROT_180: begin
                            nx = W - 1 - sx;
                            ny = H - 1 - sy;
                        end
                        ROT_270: begin
                            nx = sy;
                            ny = H - 1 - sx;
                        end
                        default: begin
                            nx = sx;
                            ny = sy;
                        end
                    endcase
                    if (nx >= 0 && nx < W && ny >= 0 && ny < H) begin
                        addr = (ny / PAGE_ROWS) * W + nx;
                        mask = BYTE_W'(1) << (ny % PAGE_ROWS);
                        case (color)
                            COLOR_SET:    frame[addr] = frame[addr] | mask;
                            COLOR_CLEAR:  frame[addr] = frame[addr] & ~mask;
                            COLOR_TOGGLE: frame[addr] = frame[addr] ^ mask;
                            default: ;
                        endcase
                        res.pixel_written = 1'b1;
                    end
                end
            end else if (cmd == CMD_CLEAR) begin
                foreach (frame[i]) frame[i] = '0;
            end else if (cmd == CMD_READ) begin
                if (idx < STORE_BYTES) res.read_byte = frame[idx];
            end
            awaited.push_back(res);
        endfunction

        function void check_result(logic [BYTE_W-1:0] rd, logic wr);
            t_pixel_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result beat: expected none, %s %h %b",
                         $time, "actual read_byte/pixel_written", rd, wr);
                return;
            end
            want = awaited.pop_front();
            if (rd !== want.read_byte) begin
                mismatches++;
                $display("%0t read_byte mismatch: expected %h, actual %h",
                         $time, want.read_byte, rd);
            end
            if (wr !== want.pixel_written) begin
                mismatches++;
                $display("%0t pixel_written mismatch: expected %b, actual %b",
                         $time, want.pixel_written, wr);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [ROT_W-1:0] i_cfg_wdata;

    pmfb_in_if  in_if ();
    pmfb_out_if out_if ();

    pixel_scoreboard board;
    int idle_cycles = 0;
    bit hold_request = 1'b0;
    bit send_burst = 1'b0;

    paged_mono_framebuffer_pixel_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("paged_mono_framebuffer_pixel_engine regression: fail");
        $finish;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input int x, input int y,
                             input logic [COLOR_W-1:0] color, input int idx);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.cmd        <= cmd;
        in_if.x_coord    <= COORD_W'(x);
        in_if.y_coord    <= COORD_W'(y);
        in_if.color      <= color;
        in_if.byte_index <= IDX_W'(idx);
        in_if.valid      <= 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        board.note_command(cmd, COORD_W'(x), COORD_W'(y), color, IDX_W'(idx));
    endtask

    task automatic finish_phase();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        bit burst;
        burst = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 16);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            board.check_result(out_if.read_byte, out_if.pixel_written);
        end
    end

    initial begin
        logic [ROT_W-1:0] rot_plan [6];
        int pick, area, x, y, idx;
        logic [COLOR_W-1:0] color;

        rot_plan = '{ROT_90, ROT_180, ROT_270, ROT_0, ROT_270, ROT_90};
        board = new();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= ROT_0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= CMD_DRAW;
        in_if.x_coord    <= '0;
        in_if.y_coord    <= '0;
        in_if.color      <= COLOR_CLEAR;
        in_if.byte_index <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_DRAW, 0, 0, COLOR_SET, 0);
        send_item(CMD_DRAW, W - 1, H - 1, COLOR_SET, 0);
        send_item(CMD_READ, 0, 0, COLOR_CLEAR, 0);
        send_item(CMD_READ, 0, 0, COLOR_CLEAR, STORE_BYTES - 1);
        send_item(CMD_DRAW, -256, -256, COLOR_SET, 0);
        send_item(CMD_DRAW, 255, 255, COLOR_SET, 0);
        send_item(CMD_DRAW, -1, 5, COLOR_SET, 0);
        send_item(CMD_DRAW, W, 0, COLOR_SET, 0);
        send_item(CMD_DRAW, 0, H, COLOR_SET, 0);
        send_item(CMD_DRAW, 0, 1, COLOR_KEEP, 0);
        send_item(CMD_DRAW, 0, 2, COLOR_TOGGLE, 0);
        send_item(CMD_DRAW, 0, 2, COLOR_TOGGLE, 0);
        send_item(CMD_DRAW, 0, 0, COLOR_CLEAR, 0);
        send_item(CMD_DRAW, 0, 7, COLOR_TOGGLE, 0);
        send_item(CMD_READ, 0, 0, COLOR_CLEAR, 0);
        send_item(CMD_UNUSED, 0, 0, COLOR_SET, 0);
        send_item(CMD_CLEAR, 0, 0, COLOR_SET, 0);
        send_item(CMD_READ, 0, 0, COLOR_CLEAR, STORE_BYTES - 1);
        send_item(CMD_READ, 0, 0, COLOR_CLEAR, 0);
        send_item(CMD_DRAW, W / 2, H / 2, COLOR_SET, 0);
        send_item(CMD_READ, 0, 0, COLOR_CLEAR, (H / 2 / PAGE_ROWS) * W + W / 2);

        foreach (rot_plan[p]) begin
            finish_phase();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= rot_plan[p];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            board.rotation = rot_plan[p];
            if (p == 1) hold_request = 1'b1;

            send_item(CMD_DRAW, 0, 0, COLOR_TOGGLE, 0);
            send_item(CMD_DRAW, W - 1, H - 1, COLOR_TOGGLE, 0);
            send_item(CMD_DRAW, 0, H - 1, COLOR_TOGGLE, 0);
            send_item(CMD_DRAW, W - 1, 0, COLOR_TOGGLE, 0);
            send_item(CMD_READ, 0, 0, COLOR_CLEAR, STORE_BYTES - 1);

            repeat (PHASE_BEATS) begin
                pick  = $urandom_range(0, 99);
                x     = $urandom_range(0, 511) - 256;
                y     = $urandom_range(0, 511) - 256;
                color = COLOR_W'($urandom_range(0, 3));
                idx   = $urandom_range(0, STORE_BYTES - 1);
                if (pick < 2) begin
                    send_item(CMD_CLEAR, x, y, color, idx);
                end else if (pick < 5) begin
                    send_item(CMD_UNUSED, x, y, color, idx);
                end else if (pick < 27) begin
                    if ($urandom_range(0, 2) != 0) begin
                        idx = $urandom_range(0, H / PAGE_ROWS - 1) * W
                            + ($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                    : W - 16 + $urandom_range(0, 15));
                    end
                    send_item(CMD_READ, x, y, color, idx);
                end else begin
                    area = $urandom_range(0, 99);
                    if (area < 60) begin
                        x = $urandom_range(0, 15);
                        y = $urandom_range(0, 15);
                    end else if (area < 85) begin
                        x = $urandom_range(0, W - 1);
                        y = $urandom_range(0, H - 1);
                    end
                    send_item(CMD_DRAW, x, y, color, idx);
                end
            end
        end

        finish_phase();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("paged_mono_framebuffer_pixel_engine regression: pass");
        end else begin
            $display("paged_mono_framebuffer_pixel_engine regression: fail");
        end
        $finish;
    end

endmodule
